[rtl/dltq_pkg.sv]
// Package for the delta-list timer queue.
// Field widths, beat codes, control struct and state type. No dependencies.
`default_nettype none

package dltq_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DELAY_BITS_DEF = 16;

  localparam int MODE_W = 2;
  localparam int H_W    = 4;
  localparam int A_W    = 8;
  localparam int TIME_W = 16;
  localparam int KIND_W = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADV_DONE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_ADV
  } dltq_state_t;

  // shift: whole row moves one towards the head; wr: one cell loads the push entry;
  // hupd: head cell takes a new delta
  typedef struct packed {
    logic shift;
    logic wr;
    logic hupd;
  } dltq_ctl_t;

endpackage

`default_nettype wire

[rtl/dltq_cell.sv]
// One queue slot of the delta-list timer queue: handler, argument and delta.
// Depends on dltq_pkg.
`default_nettype none

module dltq_cell
  import dltq_pkg::*;
#(
  parameter int IDX_W      = 4,
  parameter int IDX        = 0,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire dltq_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]      wr_idx,
  input  wire logic [H_W-1:0]        push_h,
  input  wire logic [A_W-1:0]        push_a,
  input  wire logic [DELAY_BITS-1:0] push_d,
  input  wire logic [DELAY_BITS-1:0] head_d,
  input  wire logic [H_W-1:0]        nxt_h,
  input  wire logic [A_W-1:0]        nxt_a,
  input  wire logic [DELAY_BITS-1:0] nxt_d,
  output logic      [H_W-1:0]        h,
  output logic      [A_W-1:0]        a,
  output logic      [DELAY_BITS-1:0] d
);

  logic sel;

  assign sel = ctl.wr && (wr_idx == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (sel) begin
      h <= push_h;
      a <= push_a;
      d <= push_d;
    end else if (ctl.shift) begin
      h <= nxt_h;
      a <= nxt_a;
      d <= nxt_d;
    end else if (ctl.hupd && (IDX == 0)) begin
      d <= head_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dltq_ctrl.sv]
// Head unit of the delta-list timer queue: sequencer, occupancy and result register.
// Works on the head cell one step a cycle unless a result beat is held at the output. Depends on dltq_pkg.
`default_nettype none

module dltq_ctrl
  import dltq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W     = $clog2(SLOTS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [H_W-1:0]        in_h,
  input  wire logic [A_W-1:0]        in_a,
  input  wire logic [TIME_W-1:0]     in_delay,
  input  wire logic [H_W-1:0]        h0,
  input  wire logic [A_W-1:0]        a0,
  input  wire logic [DELAY_BITS-1:0] d0,
  output dltq_ctl_t                  ctl,
  output logic      [IDX_W-1:0]      wr_idx,
  output logic      [H_W-1:0]        push_h,
  output logic      [A_W-1:0]        push_a,
  output logic      [DELAY_BITS-1:0] push_d,
  output logic      [DELAY_BITS-1:0] head_d,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [KIND_W-1:0]     out_kind,
  output logic      [H_W-1:0]        out_h,
  output logic      [A_W-1:0]        out_a,
  output logic      [TIME_W-1:0]     out_time,
  output logic                       out_found,
  output logic                       out_last
);

  localparam int WW = (DELAY_BITS > TIME_W) ? DELAY_BITS : TIME_W;

  dltq_state_t state, state_next;

  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [CNT_W-1:0]      r, r_next;
  logic [H_W-1:0]        hq, hq_next;
  logic [A_W-1:0]        aq, aq_next;
  logic [DELAY_BITS-1:0] t, t_next;
  logic [DELAY_BITS-1:0] carry, carry_next;
  logic [TIME_W-1:0]     run, run_next;
  logic [TIME_W-1:0]     abs_t, abs_t_next;
  logic [H_W-1:0]        fh, fh_next;
  logic [A_W-1:0]        fa, fa_next;
  logic                  placed, placed_next;
  logic                  adj, adj_next;
  logic                  hit, hit_next;
  logic                  full, full_next;

  logic [WW-1:0]         d_wide;
  logic [DELAY_BITS-1:0] d_sat;
  logic [DELAY_BITS:0]   rsum;
  logic [DELAY_BITS-1:0] dd;
  logic                  match;
  logic                  out_free;
  logic                  go;
  logic                  emit;
  logic                  pop;
  logic                  push;
  logic                  hupd;
  logic [KIND_W-1:0]     e_kind;
  logic [H_W-1:0]        e_h;
  logic [A_W-1:0]        e_a;
  logic [TIME_W-1:0]     e_time;
  logic                  e_found;
  logic                  e_last;

  assign d_wide = WW'(in_delay);
  assign d_sat  = (d_wide > WW'({DELAY_BITS{1'b1}})) ? {DELAY_BITS{1'b1}}
                                                      : d_wide[DELAY_BITS-1:0];

  assign rsum  = {1'b0, d0} + {1'b0, carry};
  assign dd    = rsum[DELAY_BITS] ? {DELAY_BITS{1'b1}} : rsum[DELAY_BITS-1:0];
  assign match = ((hq == '0) || (hq == h0)) && ((aq == '0) || (aq == a0));

  assign out_free = !out_valid || out_ready;
  assign go       = !emit || out_free;
  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_INSERT: state_next = ST_INS;
            MODE_REMOVE: state_next = ST_REM;
            default:     state_next = ST_ADV;
          endcase
        end
      end
      ST_INS: begin
        if (go && (full || (r == '0))) state_next = ST_IDLE;
      end
      ST_REM: begin
        if (go && (r == '0)) state_next = ST_IDLE;
      end
      ST_ADV: begin
        if (go && ((cnt == '0) || (d0 > t))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // step of the head unit
  always_comb begin
    emit        = 1'b0;
    pop         = 1'b0;
    push        = 1'b0;
    hupd        = 1'b0;
    push_h      = h0;
    push_a      = a0;
    push_d      = d0;
    head_d      = d0 - t;
    e_kind      = KIND_ADV_DONE;
    e_h         = '0;
    e_a         = '0;
    e_time      = '0;
    e_found     = 1'b0;
    e_last      = 1'b1;
    hq_next     = hq;
    aq_next     = aq;
    t_next      = t;
    carry_next  = carry;
    run_next    = run;
    abs_t_next  = abs_t;
    fh_next     = fh;
    fa_next     = fa;
    placed_next = placed;
    adj_next    = adj;
    hit_next    = hit;
    full_next   = full;
    r_next      = r;
    case (state)
      ST_IDLE: begin
        hq_next     = in_h;
        aq_next     = in_a;
        t_next      = ((in_mode == MODE_INSERT) || (in_mode == MODE_ADVANCE)) ? d_sat : '0;
        carry_next  = '0;
        run_next    = '0;
        abs_t_next  = '0;
        fh_next     = '0;
        fa_next     = '0;
        placed_next = 1'b0;
        adj_next    = 1'b0;
        hit_next    = 1'b0;
        full_next   = (cnt == CNT_W'(SLOTS));
        r_next      = cnt;
      end
      ST_INS: begin
        if (full) begin
          emit   = 1'b1;
          e_kind = KIND_FULL;
        end else begin
          if (!placed && ((r == '0) || (d0 > t))) begin
            push        = 1'b1;
            push_h      = hq;
            push_a      = aq;
            push_d      = t;
            placed_next = 1'b1;
            adj_next    = 1'b1;
          end else if (r != '0) begin
            pop    = 1'b1;
            push   = 1'b1;
            r_next = r - CNT_W'(1);
            if (!placed) begin
              t_next = t - d0;
            end else begin
              push_d   = adj ? (d0 - t) : d0;
              adj_next = 1'b0;
            end
          end
          if (r == '0) begin
            emit   = 1'b1;
            e_kind = KIND_INSERTED;
          end
        end
      end
      ST_REM: begin
        if (r == '0) begin
          emit    = 1'b1;
          e_kind  = KIND_REMOVED;
          e_h     = fh;
          e_a     = fa;
          e_time  = abs_t;
          e_found = hit;
        end else begin
          pop    = 1'b1;
          r_next = r - CNT_W'(1);
          if (match) begin
            hit_next   = 1'b1;
            fh_next    = h0;
            fa_next    = a0;
            abs_t_next = run + TIME_W'(dd);
            carry_next = dd;
          end else begin
            push       = 1'b1;
            push_d     = dd;
            run_next   = run + TIME_W'(dd);
            carry_next = '0;
          end
        end
      end
      ST_ADV: begin
        emit = 1'b1;
        if (cnt == '0) begin
          e_kind = KIND_ADV_DONE;
        end else if (d0 > t) begin
          hupd    = 1'b1;
          e_kind  = KIND_ADV_DONE;
          e_time  = TIME_W'(head_d);
          e_found = 1'b1;
        end else begin
          pop    = 1'b1;
          t_next = t - d0;
          e_kind = KIND_EXPIRED;
          e_h    = h0;
          e_a    = a0;
          e_last = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign ctl.shift = pop && go;
  assign ctl.wr    = push && go;
  assign ctl.hupd  = hupd && go;
  assign wr_idx    = pop ? IDX_W'(cnt - CNT_W'(1)) : IDX_W'(cnt);

  always_comb begin
    cnt_next = cnt;
    if (pop && !push) begin
      cnt_next = cnt - CNT_W'(1);
    end else if (!pop && push) begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        state <= state_next;
        cnt   <= cnt_next;
      end
      if (emit && go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hq     <= hq_next;
      aq     <= aq_next;
      t      <= t_next;
      carry  <= carry_next;
      run    <= run_next;
      abs_t  <= abs_t_next;
      fh     <= fh_next;
      fa     <= fa_next;
      placed <= placed_next;
      adj    <= adj_next;
      hit    <= hit_next;
      full   <= full_next;
      r      <= r_next;
    end
    if (emit && go) begin
      out_kind  <= e_kind;
      out_h     <= e_h;
      out_a     <= e_a;
      out_time  <= e_time;
      out_found <= e_found;
      out_last  <= e_last;
    end
  end

endmodule

`default_nettype wire

[rtl/delta_list_timer_queue_unit.sv]
// Top level of the delta-list timer queue: a row of slot cells and the head unit.
// Depends on dltq_pkg, dltq_cell and dltq_ctrl.
//
// Timers sit in a row of SLOTS cells in due order, each holding its delay relative to
// the one before. A single head unit looks at cell 0 once per cycle unless a result
// beat is held at the output; the row shifts towards it and reordered entries are
// written back behind the untouched ones. Each beat is taken and then worked off by
// the head unit visiting the queued timers in turn; an advance stops at the first
// timer not yet due, and an insert on a full queue is refused. A new beat is taken
// only once the previous one is fully worked off, though its last result may still
// sit in the output register. A result beat stalls the queue while the output
// register is held.
`default_nettype none

module delta_list_timer_queue_unit
  import dltq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [31:0]       s_tdata,   // handler_id[3:0], arg_id[11:4], delay_ms[27:12]
  input  wire logic [MODE_W-1:0] s_tuser,   // mode
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [31:0]       m_tdata,   // handler_id_out[3:0], arg_id_out[11:4],
                                            // time_ms[27:12], found[28]
  output logic      [KIND_W-1:0] m_tuser,   // kind
  output logic                   m_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  dltq_ctl_t             ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [H_W-1:0]        push_h;
  logic [A_W-1:0]        push_a;
  logic [DELAY_BITS-1:0] push_d;
  logic [DELAY_BITS-1:0] head_d;
  logic [H_W-1:0]        c_h [SLOTS+1];
  logic [A_W-1:0]        c_a [SLOTS+1];
  logic [DELAY_BITS-1:0] c_d [SLOTS+1];
  logic [H_W-1:0]        o_h;
  logic [A_W-1:0]        o_a;
  logic [TIME_W-1:0]     o_time;
  logic                  o_found;

  assign c_h[SLOTS] = '0;
  assign c_a[SLOTS] = '0;
  assign c_d[SLOTS] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    dltq_cell #(
      .IDX_W      (IDX_W),
      .IDX        (k),
      .DELAY_BITS (DELAY_BITS)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .push_h (push_h),
      .push_a (push_a),
      .push_d (push_d),
      .head_d (head_d),
      .nxt_h  (c_h[k+1]),
      .nxt_a  (c_a[k+1]),
      .nxt_d  (c_d[k+1]),
      .h      (c_h[k]),
      .a      (c_a[k]),
      .d      (c_d[k])
    );
  end

  dltq_ctrl #(
    .SLOTS      (SLOTS),
    .DELAY_BITS (DELAY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_h      (s_tdata[3:0]),
    .in_a      (s_tdata[11:4]),
    .in_delay  (s_tdata[27:12]),
    .h0        (c_h[0]),
    .a0        (c_a[0]),
    .d0        (c_d[0]),
    .ctl       (ctl),
    .wr_idx    (wr_idx),
    .push_h    (push_h),
    .push_a    (push_a),
    .push_d    (push_d),
    .head_d    (head_d),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_h     (o_h),
    .out_a     (o_a),
    .out_time  (o_time),
    .out_found (o_found),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'b000, o_found, o_time, o_a, o_h};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("queue took a beat without going busy");

  a_row_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.shift || ctl.wr || ctl.hupd |-> !s_tready)
    else $error("queue row changed while idle");

  a_hupd_alone: assert property (@(posedge clk) disable iff (rst)
    ctl.hupd |-> !ctl.shift && !ctl.wr)
    else $error("head delta update clashed with a row move");

  a_only_expiry_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == KIND_EXPIRED)
    else $error("non-final result beat is not an expiry");

endmodule

`default_nettype wire
